FILE: sv/gn2d_pkg.sv
// shared widths, output limits and pipeline stage vector for the gradient noise unit
package gn2d_pkg;

  // coordinate and result field widths
  localparam int COORD_W = 32;
  localparam int NOISE_W = 20;

  // saturation limits of the result
  localparam int NOISE_MAX = 524287;
  localparam int NOISE_MIN = -524288;

  // register stages from input to output
  localparam int NUM_STAGES = 8;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

endpackage

FILE: sv/gn2d_prep.sv
// stage 0: cell fraction, corner gradient selection and corner dot products
module gn2d_prep import gn2d_pkg::*; #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic signed [COORD_W-1:0]  x_coord_i,
  input  logic signed [COORD_W-1:0]  y_coord_i,
  output logic        [FRAC_BITS-1:0] frac_x_o,
  output logic        [FRAC_BITS-1:0] frac_y_o,
  output logic signed [FRAC_BITS+2:0] dot_o [4]
);

  localparam int CoordBits = INT_BITS + FRAC_BITS;
  localparam int DotW      = FRAC_BITS + 3;
  localparam int HashXMul  = 1619;
  localparam int HashYMul  = 31337;
  // only the low three hash bits pick a gradient, so the multipliers reduce mod 8
  localparam logic [2:0] HashXMod = 3'(HashXMul);
  localparam logic [2:0] HashYMod = 3'(HashYMul);

  typedef enum logic [1:0] {
    GC_ZERO = 2'b00,
    GC_POS  = 2'b01,
    GC_NEG  = 2'b11
  } gcomp_e;

  localparam gcomp_e GradX [8] = '{GC_POS, GC_NEG, GC_ZERO, GC_ZERO,
                                   GC_POS, GC_NEG, GC_POS,  GC_NEG};
  localparam gcomp_e GradY [8] = '{GC_ZERO, GC_ZERO, GC_POS, GC_NEG,
                                   GC_POS,  GC_POS,  GC_NEG, GC_NEG};

  function automatic logic [2:0] grad_index(logic [2:0] cx, logic [2:0] cy);
    return cx * HashXMod + cy * HashYMod;
  endfunction

  function automatic logic signed [DotW-1:0] grad_term(gcomp_e c,
                                                        logic signed [FRAC_BITS:0] d);
    logic signed [DotW-1:0] de;
    logic signed [DotW-1:0] res;
    de = DotW'(d);
    unique case (c)
      GC_POS:  res = de;
      GC_NEG:  res = -de;
      GC_ZERO: res = '0;
      default: res = '0;
    endcase
    return res;
  endfunction

  logic [63:0]            x_ext, y_ext;
  logic [CoordBits-1:0]   x_raw, y_raw;
  logic [FRAC_BITS-1:0]   fx, fy;
  logic [2:0]             cx0, cy0, cx1, cy1;
  logic signed [FRAC_BITS:0] dx0, dx1, dy0, dy1;
  logic [2:0]             g [4];
  logic signed [DotW-1:0] dot_d [4];

  // bits above the field width read as zero
  assign x_ext = {32'b0, x_coord_i};
  assign y_ext = {32'b0, y_coord_i};
  assign x_raw = x_ext[CoordBits-1:0];
  assign y_raw = y_ext[CoordBits-1:0];

  assign fx = x_raw[FRAC_BITS-1:0];
  assign fy = y_raw[FRAC_BITS-1:0];

  // low bits of the floored cell index, far corner wraps
  assign cx0 = x_raw[FRAC_BITS+2:FRAC_BITS];
  assign cy0 = y_raw[FRAC_BITS+2:FRAC_BITS];
  assign cx1 = cx0 + 3'd1;
  assign cy1 = cy0 + 3'd1;

  // offsets t and t - 1.0
  assign dx0 = $signed({1'b0, fx});
  assign dx1 = $signed({1'b1, fx});
  assign dy0 = $signed({1'b0, fy});
  assign dy1 = $signed({1'b1, fy});

  assign g[0] = grad_index(cx0, cy0);
  assign g[1] = grad_index(cx1, cy0);
  assign g[2] = grad_index(cx0, cy1);
  assign g[3] = grad_index(cx1, cy1);

  assign dot_d[0] = grad_term(GradX[g[0]], dx0) + grad_term(GradY[g[0]], dy0);
  assign dot_d[1] = grad_term(GradX[g[1]], dx1) + grad_term(GradY[g[1]], dy0);
  assign dot_d[2] = grad_term(GradX[g[2]], dx0) + grad_term(GradY[g[2]], dy1);
  assign dot_d[3] = grad_term(GradX[g[3]], dx1) + grad_term(GradY[g[3]], dy1);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frac_x_o <= fx;
      frac_y_o <= fy;
      for (int c = 0; c < 4; c++) begin
        dot_o[c] <= dot_d[c];
      end
    end
  end

endmodule

FILE: sv/gn2d_fade.sv
// three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 on a fraction
module gn2d_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [2:0]           load_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   w_o
);

  localparam int LinW = FRAC_BITS + 5;
  localparam longint Scale = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [LinW-1:0] FifteenS = LinW'(15 * Scale);
  localparam logic signed [LinW-1:0] TenS     = LinW'(10 * Scale);

  // stage a: t^2 and (6t - 15) * t
  logic        [2*FRAC_BITS-1:0] sq;
  logic signed [LinW-1:0]        t_s;
  logic signed [LinW-1:0]        lin;
  logic signed [2*FRAC_BITS+5:0] lin_prod;
  logic        [FRAC_BITS-1:0]   t2_q, t_a_q;
  logic signed [LinW-1:0]        pl_q;

  assign sq       = t_i * t_i;
  assign t_s      = $signed({5'b0, t_i});
  assign lin      = (t_s <<< 2) + (t_s <<< 1) - FifteenS;
  assign lin_prod = lin * $signed({1'b0, t_i});

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      t2_q  <= sq[2*FRAC_BITS-1:FRAC_BITS];
      t_a_q <= t_i;
      pl_q  <= lin_prod[2*FRAC_BITS+4:FRAC_BITS];
    end
  end

  // stage b: t^3 and the inner polynomial
  logic [2*FRAC_BITS-1:0] cube;
  logic signed [LinW-1:0] u_sum;
  logic [FRAC_BITS-1:0]   t3_q;
  logic [FRAC_BITS+3:0]   u_q;

  assign cube  = t2_q * t_a_q;
  assign u_sum = pl_q + TenS;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      t3_q <= cube[2*FRAC_BITS-1:FRAC_BITS];
      u_q  <= u_sum[FRAC_BITS+3:0];
    end
  end

  // stage c: weight, never above 1.0
  logic [2*FRAC_BITS+3:0] wprod;

  assign wprod = t3_q * u_q;

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      w_o <= wprod[2*FRAC_BITS:FRAC_BITS];
    end
  end

endmodule

FILE: sv/gn2d_lerp.sv
// dot product delay line, two-level interpolation and output saturation
module gn2d_lerp import gn2d_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  stage_vec_t                  load_i,
  input  logic signed [FRAC_BITS+2:0] dot_i [4],
  input  logic        [FRAC_BITS:0]   wx_i,
  input  logic        [FRAC_BITS:0]   wy_i,
  output logic signed [NOISE_W-1:0]   noise_value_o
);

  localparam int DotW  = FRAC_BITS + 3;
  localparam int DiffW = FRAC_BITS + 4;
  localparam int ProdW = DiffW + FRAC_BITS + 2;

  // stages 1..3: dot products wait for the fade weights
  logic signed [DotW-1:0] dot_q [3][4];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 3; s++) begin
      if (load_i[s+1]) begin
        for (int c = 0; c < 4; c++) begin
          dot_q[s][c] <= (s == 0) ? dot_i[c] : dot_q[(s == 0) ? 0 : s-1][c];
        end
      end
    end
  end

  // stage 4: scaled differences along x
  logic signed [DiffW-1:0] dx0, dx1;
  logic signed [ProdW-1:0] px0, px1;
  logic signed [DiffW-1:0] p0_q, p1_q;
  logic signed [DotW-1:0]  a0_q, a1_q;
  logic        [FRAC_BITS:0] wy4_q, wy5_q;

  assign dx0 = DiffW'(dot_q[2][1]) - DiffW'(dot_q[2][0]);
  assign dx1 = DiffW'(dot_q[2][3]) - DiffW'(dot_q[2][2]);
  assign px0 = dx0 * $signed({1'b0, wx_i});
  assign px1 = dx1 * $signed({1'b0, wx_i});

  always_ff @(posedge clk_i) begin
    if (load_i[4]) begin
      p0_q  <= px0[FRAC_BITS+DiffW-1:FRAC_BITS];
      p1_q  <= px1[FRAC_BITS+DiffW-1:FRAC_BITS];
      a0_q  <= dot_q[2][0];
      a1_q  <= dot_q[2][2];
      wy4_q <= wy_i;
    end
  end

  // stage 5: row values
  logic signed [DiffW-1:0] r0_sum, r1_sum;
  logic signed [DotW-1:0]  row0_q, row1_q;

  assign r0_sum = DiffW'(a0_q) + p0_q;
  assign r1_sum = DiffW'(a1_q) + p1_q;

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      row0_q <= r0_sum[DotW-1:0];
      row1_q <= r1_sum[DotW-1:0];
      wy5_q  <= wy4_q;
    end
  end

  // stage 6: scaled difference along y
  logic signed [DiffW-1:0] dy;
  logic signed [ProdW-1:0] py;
  logic signed [DiffW-1:0] pd_q;
  logic signed [DotW-1:0]  row0_6_q;

  assign dy = DiffW'(row1_q) - DiffW'(row0_q);
  assign py = dy * $signed({1'b0, wy5_q});

  always_ff @(posedge clk_i) begin
    if (load_i[6]) begin
      pd_q     <= py[FRAC_BITS+DiffW-1:FRAC_BITS];
      row0_6_q <= row0_q;
    end
  end

  // stage 7: final sum and clamp into the result range
  logic signed [DiffW-1:0]   v;
  logic signed [31:0]        v32;
  logic signed [NOISE_W-1:0] noise_d;

  assign v   = DiffW'(row0_6_q) + pd_q;
  assign v32 = 32'(v);

  always_comb begin
    priority if (v32 > NOISE_MAX) begin
      noise_d = NOISE_W'(NOISE_MAX);
    end else if (v32 < NOISE_MIN) begin
      noise_d = NOISE_W'(NOISE_MIN);
    end else begin
      noise_d = v32[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[7]) begin
      noise_value_o <= noise_d;
    end
  end

endmodule

FILE: sv/gradient_noise_2d_unit.sv
// gradient noise unit: fixed-point 2d gradient noise, one point per clock while not stalled
// Evaluates 2d gradient noise at one point (x, y) given as signed fixed point with
// FRAC_BITS fraction bits (Q16.16 by default) and returns one signed value with the
// same number of fraction bits in 20 bits, saturated. The cell is the floor of each
// coordinate, so negative coordinates land in the correct cell. Each of the four cell
// corners picks one of eight axis or diagonal gradients from a wrapping hash of its
// cell coordinates; the corner dot products are blended with the quintic fade curve,
// first along x and then along y. There is no state and nothing to configure. The
// datapath is an eight-stage pipeline (fraction and dot products, three fade stages,
// two stages per interpolation level with the output register last): a new point is
// accepted every cycle unless every stage is full and the output is stalled, and each
// point passes through the stages in order to the output register behind out_valid_o.
// Every stage carries its own valid bit and only holds
// when its successor is full and stalled, so bubbles are squeezed out and input keeps
// flowing while results wait, until all eight stages are occupied.
module gradient_noise_2d_unit import gn2d_pkg::*; #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [NOISE_W-1:0] noise_value_o
);

  // largest magnitude the blended value can reach, capped by the output range
  localparam int NoiseBound = (FRAC_BITS >= 18) ? (NOISE_MAX + 1) : (1 << (FRAC_BITS + 1));

  // per-stage valid bits and load enables
  stage_vec_t valid_q, valid_d;
  stage_vec_t load;

  // a stage loads when it is empty or when the stage after it moves on
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  // stage 0: fractions and corner dot products
  logic        [FRAC_BITS-1:0] frac_x, frac_y;
  logic signed [FRAC_BITS+2:0] dot [4];

  gn2d_prep #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk_i     (clk_i),
    .load_i    (load[0]),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .frac_x_o  (frac_x),
    .frac_y_o  (frac_y),
    .dot_o     (dot)
  );

  // stages 1..3: fade weights for both axes side by side
  logic [FRAC_BITS:0] wx, wy;

  gn2d_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade_x (
    .clk_i  (clk_i),
    .load_i (load[3:1]),
    .t_i    (frac_x),
    .w_o    (wx)
  );

  gn2d_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade_y (
    .clk_i  (clk_i),
    .load_i (load[3:1]),
    .t_i    (frac_y),
    .w_o    (wy)
  );

  // stages 4..7: interpolation along x, then y, then the output register
  gn2d_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk_i         (clk_i),
    .load_i        (load),
    .dot_i         (dot),
    .wx_i          (wx),
    .wy_i          (wy),
    .noise_value_o (noise_value_o)
  );

  // input can only be refused when every stage is full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q) && !out_ready_i)
    else $error("input refused while the pipeline has room");

  // an accepted transaction always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted transaction lost at pipeline entry");

  // stage one only becomes valid when stage zero held a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q[1]) |-> $past(valid_q[0]))
    else $error("transaction appeared from nowhere in stage one");

  // a blend of dot products never exceeds two units in magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= NoiseBound) && (noise_value_o >= -NoiseBound))
    else $error("noise value outside the reachable range");

endmodule
